### design/sparse_column_predictor_defines.svh
// Assertion macros shared by the checker files of the sparse column predictor.
// Each macro expects a signal named clock, and SCP_ASSERT also one named reset, in the scope where it is used.
`ifndef SPARSE_COLUMN_PREDICTOR_DEFINES_SVH
`define SPARSE_COLUMN_PREDICTOR_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define SCP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SCP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/scp_pkg.sv
`timescale 1ns / 1ps
// Package of the sparse column predictor: geometry constants, request codes,
// register indexes and the logistic lookup table. Depends on nothing.
package scp_pkg;

   localparam int HID_COLS  = 16;
   localparam int HID_CELLS = 8;
   localparam int VIS_CELLS = 8;
   localparam int VIS_MAX   = 16;
   localparam int RADIUS    = 1;

   localparam int DIAM   = 2 * RADIUS + 1;
   localparam int FIELD  = DIAM * DIAM;
   localparam int WROW   = HID_COLS * HID_CELLS;
   localparam int WDEPTH = WROW * FIELD * VIS_CELLS;
   localparam int VPLANE = VIS_MAX * VIS_MAX;

   localparam int WADDR_W  = 14;
   localparam int VADDR_W  = 9;
   localparam int CNT_W    = $clog2(FIELD + 1);
   localparam int SCORE_W  = 21;
   localparam int WEIGHT_W = 16;
   localparam int DELTA_W  = 14;

   localparam logic [2:0] MODE_WRITE_VIS    = 3'd0;
   localparam logic [2:0] MODE_WRITE_WEIGHT = 3'd1;
   localparam logic [2:0] MODE_READ_WEIGHT  = 3'd2;
   localparam logic [2:0] MODE_FORWARD      = 3'd3;
   localparam logic [2:0] MODE_LEARN        = 3'd4;

   localparam logic [1:0] CSR_VIS_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_VIS_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_LEARN_RATE = 2'd2;

   typedef logic [11:0] sig_table_type [256];

   // Logistic curve in Q0.12, built from repeated powers of exp(-1/16).
   // The rounded quotient comes from a shift and subtract loop.
   function automatic sig_table_type make_sigmoid();
      logic [95:0]   prod;
      logic [63:0]   p;
      logic [63:0]   den;
      logic [63:0]   s;
      logic [63:0]   num;
      logic [63:0]   rem;
      sig_table_type t;
      p = 64'h1_0000_0000;
      for (int k = 0; k <= 128; k++) begin
         den = 64'h1_0000_0000 + p;
         num = (64'd1 << 44) + (den >> 1);
         s   = '0;
         rem = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem  = rem - den;
               s[b] = 1'b1;
            end
         end
         if (k <= 127) begin
            t[128 + k] = (s > 64'd4095) ? 12'd4095 : s[11:0];
         end
         if (k >= 1) begin
            t[128 - k] = 12'(64'd4096 - s);
         end
         prod = {32'd0, p} * 96'd4034748381;
         p    = prod[95:32];
      end
      return t;
   endfunction

   localparam sig_table_type SIGMOID_TABLE = make_sigmoid();

endpackage

### design/scp_divider.sv
`timescale 1ns / 1ps
// Restoring divider of the sparse column predictor: one quotient bit a cycle.
// Depends on scp_pkg for the score and count widths.
module scp_divider import scp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SCORE_W-1:0] dividend,
   input  logic [CNT_W-1:0]   divisor,
   output logic               done,
   output logic [SCORE_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SCORE_W + 1);

   logic               running_ff, running_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SCORE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     diff;
   logic               ge;

   assign trial = {rem_ff, quo_ff[SCORE_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      if (start) begin
         running_in = 1'b1;
         step_in    = '0;
         quo_in     = dividend;
         rem_in     = '0;
      end else if (running_ff) begin
         // The remainder stays below the divisor, so its low bits hold it.
         rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SCORE_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SCORE_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/sparse_column_predictor.sv
`timescale 1ns / 1ps
// Top level of the sparse column predictor: sequencer, weight and visible memories.
// Depends on scp_pkg and scp_divider.
//
// Visible and weight writes answer in the next cycle. A weight read passes through
// S_RDW, where the registered memory output becomes the result. Forward and learn
// walk the cells one at a time; every field position takes, per layer, a visible
// read, a weight read and an accumulate or write back, in turn, since each memory
// has a single read port. A learn, for each cell with a nonempty field, also waits
// on the divider, does the sigmoid lookup, the multiply and the rounding step, and
// makes a second walk that writes the weights back. The result strobe rsp_valid
// lasts one cycle and cannot be held off, so the receiver must take it when it
// appears; busy stays high until the result is out.
module sparse_column_predictor import scp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_mode,
   input  logic                       req_layer,
   input  logic [3:0]                 req_vis_x,
   input  logic [3:0]                 req_vis_y,
   input  logic [2:0]                 req_vis_cell,
   input  logic [13:0]                req_weight_index,
   input  logic signed [15:0]         req_weight_value,
   input  logic [3:0]                 req_hid_index,
   input  logic [3:0]                 req_center_x,
   input  logic [3:0]                 req_center_y,
   input  logic [2:0]                 req_target_cell,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_winner_cell,
   output logic signed [20:0]         rsp_winner_score,
   output logic signed [15:0]         rsp_read_value,
   output logic                       rsp_done_res,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [15:0]                csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_RDW, S_CELL, S_VRD, S_WRD, S_ACC, S_CEND, S_DIV, S_SIG, S_MUL, S_RND
   } state_type;

   // Memories.
   logic signed [WEIGHT_W-1:0] wmem [WDEPTH];
   logic [2:0]                 vmem [2 * VPLANE];

   logic [WADDR_W-1:0]         w_raddr, w_waddr;
   logic signed [WEIGHT_W-1:0] w_wdata, w_q;
   logic                       w_we;
   logic [VADDR_W-1:0]         v_raddr, v_waddr;
   logic [2:0]                 v_q;
   logic                       v_we;

   // Control and datapath registers.
   state_type                  state_ff;
   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_cell_ff;
   logic signed [SCORE_W-1:0]  rsp_score_ff;
   logic signed [WEIGHT_W-1:0] rsp_read_ff;
   logic                       rsp_done_ff;
   logic [4:0]                 vis_width_ff, vis_height_ff;
   logic [15:0]                learn_rate_ff;

   logic [2:0]                 mode_ff;
   logic [3:0]                 hid_ff, cx_ff, cy_ff;
   logic [2:0]                 target_ff;
   logic                       rd_ok_ff;
   logic [3:0]                 x0_ff, x1_ff, y0_ff, y1_ff;
   logic                       empty_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [2:0]                 hc_ff;
   logic [3:0]                 x_ff, y_ff;
   logic                       layer_ff;
   logic                       pass_ff;
   logic signed [SCORE_W-1:0]  acc_ff, best_ff;
   logic [2:0]                 best_hc_ff;
   logic [WADDR_W-1:0]         waddr_ff;
   logic signed [DELTA_W-1:0]  diff_ff;
   logic signed [30:0]         prod_ff;
   logic signed [DELTA_W-1:0]  delta_ff;

   // Field clamping from the request and the grid registers.
   logic [4:0]        wcl, hcl;
   logic signed [6:0] lx, ly, fx0, fy0, xh, yh, wm1, hm1, fx1, fy1, cntx, cnty;
   logic              fempty;
   logic [CNT_W-1:0]  fcount;

   assign wcl = (vis_width_ff > 5'(VIS_MAX)) ? 5'(VIS_MAX) : vis_width_ff;
   assign hcl = (vis_height_ff > 5'(VIS_MAX)) ? 5'(VIS_MAX) : vis_height_ff;

   always_comb begin
      lx     = 7'(req_center_x) - 7'(RADIUS);
      ly     = 7'(req_center_y) - 7'(RADIUS);
      fx0    = lx[6] ? 7'sd0 : lx;
      fy0    = ly[6] ? 7'sd0 : ly;
      xh     = 7'(req_center_x) + 7'(RADIUS);
      yh     = 7'(req_center_y) + 7'(RADIUS);
      wm1    = 7'(wcl) - 7'd1;
      hm1    = 7'(hcl) - 7'd1;
      fx1    = (xh < wm1) ? xh : wm1;
      fy1    = (yh < hm1) ? yh : hm1;
      fempty = (fx1 < fx0) || (fy1 < fy0);
      cntx   = fx1 - fx0 + 7'sd1;
      cnty   = fy1 - fy0 + 7'sd1;
      fcount = fempty ? '0 : CNT_W'(cntx[4:0] * cnty[4:0]);
   end

   // Weight address of the current position, cell and visible cell.
   logic [6:0]         ox, oy;
   logic [WADDR_W-1:0] waddr_calc;

   assign ox = 7'(x_ff) + 7'(RADIUS) - 7'(cx_ff);
   assign oy = 7'(y_ff) + 7'(RADIUS) - 7'(cy_ff);
   assign waddr_calc = (WADDR_W'(ox) + WADDR_W'(oy) * WADDR_W'(DIAM)
                        + WADDR_W'(v_q) * WADDR_W'(FIELD)) * WADDR_W'(WROW)
                       + WADDR_W'(hc_ff) * WADDR_W'(HID_COLS) + WADDR_W'(hid_ff);

   // Shared accumulate and weight update unit.
   logic signed [SCORE_W-1:0] w_ext, acc_next;
   logic signed [16:0]        nudge_sum;
   logic signed [16:0]        delta_ext;
   logic signed [WEIGHT_W-1:0] nudged;

   assign w_ext     = SCORE_W'(w_q);
   assign acc_next  = layer_ff ? acc_ff + w_ext : acc_ff - w_ext;
   assign delta_ext = layer_ff ? 17'(delta_ff) : -17'(delta_ff);
   assign nudge_sum = 17'(w_q) + delta_ext;
   assign nudged    = (nudge_sum > 17'sd32767) ? 16'sh7fff :
                      (nudge_sum < -17'sd32768) ? 16'sh8000 : nudge_sum[15:0];

   // Sigmoid index and error term.
   logic [SCORE_W-1:0]        div_q;
   logic                      div_done, div_start;
   logic signed [SCORE_W:0]   mean;
   logic signed [SCORE_W-8:0] q8;
   logic signed [SCORE_W-7:0] idx_s;
   logic [7:0]                sel;
   logic [11:0]               sig;
   logic signed [DELTA_W-1:0] tval;
   logic [SCORE_W-1:0]        acc_mag;

   assign acc_mag = acc_ff[SCORE_W-1] ? SCORE_W'(-acc_ff) : SCORE_W'(acc_ff);
   assign mean    = acc_ff[SCORE_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
   assign q8      = mean[SCORE_W:8];
   assign idx_s   = (SCORE_W-6)'(q8) + (SCORE_W-6)'(128);
   assign sel     = idx_s[SCORE_W-7] ? 8'd0 : (idx_s > (SCORE_W-6)'(255)) ? 8'd255 : idx_s[7:0];
   assign sig     = SIGMOID_TABLE[sel];
   assign tval    = (hc_ff == target_ff) ? DELTA_W'(4096) : '0;

   logic [30:0] prod_mag;
   logic [14:0] rnd;
   assign prod_mag = prod_ff[30] ? 31'(-prod_ff) : 31'(prod_ff);
   assign rnd      = 15'((prod_mag + 31'd32768) >> 16);

   // Best cell after this cell's score.
   logic                      take_best;
   logic signed [SCORE_W-1:0] best_sel;
   logic [2:0]                best_hc_sel;
   logic                      last_cell;
   assign take_best   = (hc_ff == 3'd0) || (acc_ff > best_ff);
   assign best_sel    = take_best ? acc_ff : best_ff;
   assign best_hc_sel = take_best ? hc_ff : best_hc_ff;
   assign last_cell   = hc_ff == 3'(HID_CELLS - 1);

   logic accept;
   assign accept    = start && (state_ff == S_IDLE);
   assign div_start = (state_ff == S_CEND) && (mode_ff == MODE_LEARN) && !pass_ff && !empty_ff;

   scp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_mag),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Memory port selection.
   always_comb begin
      v_raddr = {layer_ff, y_ff, x_ff};
      v_waddr = {req_layer, req_vis_y, req_vis_x};
      v_we    = accept && (req_mode == MODE_WRITE_VIS)
                && ({1'b0, req_vis_x} < 5'(VIS_MAX)) && ({1'b0, req_vis_y} < 5'(VIS_MAX))
                && ({1'b0, req_vis_cell} < 4'(VIS_CELLS));
      w_raddr = (state_ff == S_IDLE) ? req_weight_index : waddr_calc;
      if (state_ff == S_ACC) begin
         w_waddr = waddr_ff;
         w_wdata = nudged;
         w_we    = pass_ff;
      end else begin
         w_waddr = req_weight_index;
         w_wdata = req_weight_value;
         w_we    = accept && (req_mode == MODE_WRITE_WEIGHT)
                   && ({1'b0, req_weight_index} < 15'(WDEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      w_q <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vmem[v_waddr] <= req_vis_cell;
      end
      v_q <= vmem[v_raddr];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         vis_width_ff  <= 5'd16;
         vis_height_ff <= 5'd16;
         learn_rate_ff <= 16'd6554;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_VIS_WIDTH:  vis_width_ff  <= csr_data[4:0];
               CSR_VIS_HEIGHT: vis_height_ff <= csr_data[4:0];
               CSR_LEARN_RATE: learn_rate_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff      <= req_mode;
                  hid_ff       <= req_hid_index;
                  cx_ff        <= req_center_x;
                  cy_ff        <= req_center_y;
                  target_ff    <= req_target_cell;
                  x0_ff        <= fx0[3:0];
                  x1_ff        <= fx1[3:0];
                  y0_ff        <= fy0[3:0];
                  y1_ff        <= fy1[3:0];
                  empty_ff     <= fempty;
                  count_ff     <= fcount;
                  rd_ok_ff     <= {1'b0, req_weight_index} < 15'(WDEPTH);
                  hc_ff        <= '0;
                  pass_ff      <= 1'b0;
                  rsp_cell_ff  <= '0;
                  rsp_score_ff <= '0;
                  rsp_read_ff  <= '0;
                  rsp_done_ff  <= 1'b1;
                  priority if (req_mode == MODE_READ_WEIGHT) begin
                     state_ff <= S_RDW;
                  end else if ((req_mode == MODE_FORWARD || req_mode == MODE_LEARN)
                               && ({1'b0, req_hid_index} < 5'(HID_COLS))) begin
                     state_ff <= S_CELL;
                  end else if (req_mode == MODE_FORWARD || req_mode == MODE_LEARN
                               || req_mode == MODE_WRITE_VIS
                               || req_mode == MODE_WRITE_WEIGHT) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     rsp_done_ff  <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_RDW: begin
               rsp_read_ff  <= rd_ok_ff ? w_q : '0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_CELL: begin
               acc_ff   <= '0;
               x_ff     <= x0_ff;
               y_ff     <= y0_ff;
               layer_ff <= 1'b0;
               state_ff <= empty_ff ? S_CEND : S_VRD;
            end
            S_VRD: begin
               state_ff <= S_WRD;
            end
            S_WRD: begin
               waddr_ff <= waddr_calc;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (!pass_ff) begin
                  acc_ff <= acc_next;
               end
               state_ff <= S_VRD;
               if (!layer_ff) begin
                  layer_ff <= 1'b1;
               end else begin
                  layer_ff <= 1'b0;
                  priority if (y_ff != y1_ff) begin
                     y_ff <= y_ff + 4'd1;
                  end else if (x_ff != x1_ff) begin
                     x_ff <= x_ff + 4'd1;
                     y_ff <= y0_ff;
                  end else begin
                     state_ff <= S_CEND;
                  end
               end
            end
            S_CEND: begin
               if (mode_ff == MODE_FORWARD) begin
                  best_ff    <= best_sel;
                  best_hc_ff <= best_hc_sel;
                  if (last_cell) begin
                     rsp_cell_ff  <= best_hc_sel;
                     rsp_score_ff <= best_sel;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     hc_ff    <= hc_ff + 3'd1;
                     state_ff <= S_CELL;
                  end
               end else if (!pass_ff && !empty_ff) begin
                  state_ff <= S_DIV;
               end else begin
                  // Here the cell is done: its weights are written back, or its empty field changes none.
                  pass_ff <= 1'b0;
                  if (last_cell) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     hc_ff    <= hc_ff + 3'd1;
                     state_ff <= S_CELL;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_SIG;
               end
            end
            S_SIG: begin
               diff_ff  <= tval - DELTA_W'(sig);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= $signed({1'b0, learn_rate_ff}) * diff_ff;
               state_ff <= S_RND;
            end
            S_RND: begin
               delta_ff <= prod_ff[30] ? -DELTA_W'(rnd) : DELTA_W'(rnd);
               pass_ff  <= 1'b1;
               state_ff <= S_CELL;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = state_ff != S_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_winner_cell  = rsp_cell_ff;
   assign rsp_winner_score = rsp_score_ff;
   assign rsp_read_value   = rsp_read_ff;
   assign rsp_done_res     = rsp_done_ff;

endmodule

### design/scp_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the sparse column predictor, bound to the top level.
// Depends on scp_pkg and the assertion macros in sparse_column_predictor_defines.svh.
`include "sparse_column_predictor_defines.svh"

module scp_checker import scp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_mode,
   input logic               rsp_valid,
   input logic [2:0]         rsp_winner_cell,
   input logic signed [20:0] rsp_winner_score,
   input logic signed [15:0] rsp_read_value,
   input logic               rsp_done_res
);

   // A write request answers in the next cycle and leaves the block free.
   `SCP_ASSERT(a_write_answers, (start && !busy && (req_mode == MODE_WRITE_VIS || req_mode == MODE_WRITE_WEIGHT)) |=> (rsp_valid && rsp_done_res && !busy), "write request did not answer at once")

   // A request that was not done reports zeros.
   `SCP_ASSERT(a_bad_zero, (rsp_valid && !rsp_done_res) |-> (rsp_winner_cell == 3'd0 && rsp_winner_score == 21'sd0 && rsp_read_value == 16'sd0), "failed request reports nonzero fields")

   // A forward request keeps the block busy while it walks the cells.
   `SCP_ASSERT(a_forward_busy, (start && !busy && req_mode == MODE_FORWARD) |=> busy, "forward request did not occupy the block")

   `SCP_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result strobe right after reset")

endmodule

bind sparse_column_predictor scp_checker u_scp_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench of sparse_column_predictor: a predictor of scores, winners and weight
// updates checks every response. Depends on scp_pkg and the block's RTL.
module tb_top;
   import scp_pkg::*;

   localparam logic [1:0] CSR_RESERVED = 2'd3;
   localparam logic [2:0] MODE_BAD_LOW = 3'd5;

   typedef struct {
      logic [2:0]         mode;
      logic               layer;
      logic [3:0]         vis_x;
      logic [3:0]         vis_y;
      logic [2:0]         vis_cell;
      logic [13:0]        weight_index;
      logic signed [15:0] weight_value;
      logic [3:0]         hid_index;
      logic [3:0]         center_x;
      logic [3:0]         center_y;
      logic [2:0]         target_cell;
   } request_t;

   typedef struct {
      logic [2:0]         winner_cell;
      logic signed [20:0] score;
      logic signed [15:0] read_value;
      logic               done;
   } response_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_mode = '0;
   logic req_layer = 0;
   logic [3:0] req_vis_x = '0, req_vis_y = '0;
   logic [2:0] req_vis_cell = '0;
   logic [13:0] req_weight_index = '0;
   logic signed [15:0] req_weight_value = '0;
   logic [3:0] req_hid_index = '0, req_center_x = '0, req_center_y = '0;
   logic [2:0] req_target_cell = '0;
   logic rsp_valid;
   logic [2:0] rsp_winner_cell;
   logic signed [20:0] rsp_winner_score;
   logic signed [15:0] rsp_read_value;
   logic rsp_done_res;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   sparse_column_predictor dut (.*);

   always #4 clock = ~clock;

   // Shadow state of the block.
   logic signed [15:0] weights [WDEPTH];
   logic [2:0]         visible [2 * VPLANE];
   logic [11:0]        logistic [256];
   int unsigned        grid_w = 16, grid_h = 16, alpha = 6554;

   response_t pending_responses [$];
   int fail_count = 0;
   int idle_pct = 0;

   function automatic longint saturate(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic int weight_addr(int hid, int hc, int lx, int ly, int x, int y,
                                      int layer);
      int c;
      c = visible[layer * VPLANE + y * VIS_MAX + x];
      return hid + hc * HID_COLS + ((x - lx) + (y - ly) * DIAM + c * FIELD) * WROW;
   endfunction

   function automatic longint score_cell(int hid, int hc, int lx, int ly,
                                         int x0, int x1, int y0, int y1);
      longint sum;
      sum = 0;
      for (int x = x0; x <= x1; x++) begin
         for (int y = y0; y <= y1; y++) begin
            sum -= weights[weight_addr(hid, hc, lx, ly, x, y, 0)];
            sum += weights[weight_addr(hid, hc, lx, ly, x, y, 1)];
         end
      end
      return saturate(sum, SCORE_W);
   endfunction

   // Applies one request to the shadow state and returns the response it causes.
   function automatic response_t predict_response(request_t r);
      response_t e;
      int w, h, lx, ly, x0, x1, y0, y1, hid, best;
      longint cnt, s, best_s, mean, q, idx, t, prod, mag, delta;
      e = '{winner_cell: '0, score: '0, read_value: '0, done: 1'b1};
      w = grid_w > VIS_MAX ? VIS_MAX : grid_w;
      h = grid_h > VIS_MAX ? VIS_MAX : grid_h;
      lx = int'(r.center_x) - RADIUS;
      ly = int'(r.center_y) - RADIUS;
      x0 = lx < 0 ? 0 : lx;
      y0 = ly < 0 ? 0 : ly;
      x1 = int'(r.center_x) + RADIUS < w - 1 ? int'(r.center_x) + RADIUS : w - 1;
      y1 = int'(r.center_y) + RADIUS < h - 1 ? int'(r.center_y) + RADIUS : h - 1;
      cnt = (x1 >= x0 && y1 >= y0) ? longint'(x1 - x0 + 1) * (y1 - y0 + 1) : 0;
      hid = r.hid_index;
      case (r.mode)
         MODE_WRITE_VIS: begin
            visible[r.layer * VPLANE + r.vis_y * VIS_MAX + r.vis_x] = r.vis_cell;
         end
         MODE_WRITE_WEIGHT: begin
            if (r.weight_index < WDEPTH) weights[r.weight_index] = r.weight_value;
         end
         MODE_READ_WEIGHT: begin
            if (r.weight_index < WDEPTH) e.read_value = weights[r.weight_index];
         end
         MODE_FORWARD: begin
            best = 0;
            best_s = 0;
            for (int hc = 0; hc < HID_CELLS; hc++) begin
               s = score_cell(hid, hc, lx, ly, x0, x1, y0, y1);
               if (hc == 0 || s > best_s) begin
                  best_s = s;
                  best = hc;
               end
            end
            e.winner_cell = 3'(best);
            e.score = 21'(best_s);
         end
         MODE_LEARN: begin
            for (int hc = 0; hc < HID_CELLS; hc++) begin
               s = score_cell(hid, hc, lx, ly, x0, x1, y0, y1);
               mean = cnt > 0 ? s / cnt : 0;
               q = mean < 0 ? -((-mean + 255) / 256) : mean / 256;
               idx = q + 128;
               if (idx < 0) idx = 0;
               if (idx > 255) idx = 255;
               t = (hc == r.target_cell) ? 4096 : 0;
               prod = longint'(alpha) * (t - longint'(logistic[idx]));
               mag = prod < 0 ? -prod : prod;
               delta = (mag + 32768) >>> 16;
               if (prod < 0) delta = -delta;
               for (int x = x0; x <= x1; x++) begin
                  for (int y = y0; y <= y1; y++) begin
                     int a0, a1;
                     a0 = weight_addr(hid, hc, lx, ly, x, y, 0);
                     a1 = weight_addr(hid, hc, lx, ly, x, y, 1);
                     weights[a0] = saturate(longint'(weights[a0]) - delta, WEIGHT_W);
                     weights[a1] = saturate(longint'(weights[a1]) + delta, WEIGHT_W);
                  end
               end
            end
         end
         default: e.done = 1'b0;
      endcase
      return e;
   endfunction

   initial begin
      logic [95:0] p, prod;
      logic [95:0] den, s;
      p = 96'h1_0000_0000;
      for (int k = 0; k <= 128; k++) begin
         den = 96'h1_0000_0000 + p;
         s = ((96'd1 << 44) + den / 2) / den;
         if (k <= 127) logistic[128 + k] = s > 4095 ? 12'd4095 : s[11:0];
         if (k >= 1) logistic[128 - k] = 12'(4096 - s);
         prod = p * 96'd4034748381;
         p = prod >> 32;
      end
   end

   // Response checker: the block cannot be held off, so every strobe is taken.
   always @(posedge clock) begin
      response_t e;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: response with no request pending", $time);
            fail_count++;
         end else begin
            e = pending_responses.pop_front();
            if (rsp_winner_cell !== e.winner_cell) begin
               $display("%0t: winner_cell expected %0d actual %0d", $time, e.winner_cell,
                        rsp_winner_cell);
               fail_count++;
            end
            if (rsp_winner_score !== e.score) begin
               $display("%0t: winner_score expected %0d actual %0d", $time, e.score,
                        rsp_winner_score);
               fail_count++;
            end
            if (rsp_read_value !== e.read_value) begin
               $display("%0t: read_value expected %0d actual %0d", $time, e.read_value,
                        rsp_read_value);
               fail_count++;
            end
            if (rsp_done_res !== e.done) begin
               $display("%0t: done_res expected %0d actual %0d", $time, e.done,
                        rsp_done_res);
               fail_count++;
            end
         end
      end
   end

   // Leaves start high so back-to-back requests follow directly, unless an idle gap is drawn at random.
   task automatic send_request(request_t r);
      int gap;
      start <= 1'b1;
      req_mode <= r.mode;
      req_layer <= r.layer;
      req_vis_x <= r.vis_x;
      req_vis_y <= r.vis_y;
      req_vis_cell <= r.vis_cell;
      req_weight_index <= r.weight_index;
      req_weight_value <= r.weight_value;
      req_hid_index <= r.hid_index;
      req_center_x <= r.center_x;
      req_center_y <= r.center_y;
      req_target_cell <= r.target_cell;
      do @(posedge clock); while (busy);
      pending_responses.push_back(predict_response(r));
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_VIS_WIDTH: grid_w = data[4:0];
         CSR_VIS_HEIGHT: grid_h = data[4:0];
         CSR_LEARN_RATE: alpha = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(int w, int h, int rate);
      drain();
      write_csr(CSR_VIS_WIDTH, 16'(w));
      write_csr(CSR_VIS_HEIGHT, 16'(h));
      write_csr(CSR_LEARN_RATE, 16'(rate));
   endtask

   function automatic request_t blank_request(logic [2:0] mode);
      request_t r;
      r = '{mode: mode, layer: 0, vis_x: 0, vis_y: 0, vis_cell: 0, weight_index: 0,
            weight_value: 0, hid_index: 0, center_x: 0, center_y: 0, target_cell: 0};
      return r;
   endfunction

   function automatic logic signed [15:0] random_weight();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 4095)) - 2048);
      endcase
   endfunction

   // Forward and learn use the outer hidden columns and the outer visible cell
   // values only, so a short preload defines every weight they can reach.
   function automatic logic [3:0] pick_hid();
      return $urandom_range(1) ? 4'(HID_COLS - 1) : 4'd0;
   endfunction

   function automatic logic [2:0] pick_vis_cell();
      return $urandom_range(1) ? 3'(VIS_CELLS - 1) : 3'd0;
   endfunction

   function automatic logic [13:0] used_weight_addr(int hid, int hc, int off, int c);
      return 14'(hid + hc * HID_COLS + (off + c * FIELD) * WROW);
   endfunction

   // Mostly preloaded entries, sometimes an index beyond the store.
   function automatic logic [13:0] pick_weight_addr();
      if ($urandom_range(9) == 0) return 14'($urandom_range(WDEPTH, 16383));
      return used_weight_addr(int'(pick_hid()), int'($urandom_range(HID_CELLS - 1)),
                              int'($urandom_range(FIELD - 1)), int'(pick_vis_cell()));
   endfunction

   function automatic request_t random_request();
      request_t r;
      int pick;
      r.mode = MODE_FORWARD;
      r.layer = 1'($urandom_range(1));
      r.vis_x = 4'($urandom);
      r.vis_y = 4'($urandom);
      r.vis_cell = pick_vis_cell();
      r.weight_index = pick_weight_addr();
      r.weight_value = random_weight();
      r.hid_index = pick_hid();
      r.center_x = 4'($urandom);
      r.center_y = 4'($urandom);
      r.target_cell = 3'($urandom);
      pick = $urandom_range(99);
      if (pick < 15) r.mode = MODE_WRITE_VIS;
      else if (pick < 30) r.mode = MODE_WRITE_WEIGHT;
      else if (pick < 45) r.mode = MODE_READ_WEIGHT;
      else if (pick < 70) r.mode = MODE_FORWARD;
      else if (pick < 95) r.mode = MODE_LEARN;
      else r.mode = 3'($urandom_range(MODE_BAD_LOW, 7));
      return r;
   endfunction

   // Every visible entry and every weight that forward and learn can reach gets a
   // value, so later reads are all defined.
   task automatic test_preload();
      request_t r;
      for (int a = 0; a < 2 * VPLANE; a++) begin
         r = blank_request(MODE_WRITE_VIS);
         r.layer = 1'(a / VPLANE);
         r.vis_y = 4'((a % VPLANE) / VIS_MAX);
         r.vis_x = 4'(a % VIS_MAX);
         r.vis_cell = pick_vis_cell();
         send_request(r);
      end
      for (int hi = 0; hi < 2; hi++) begin
         for (int hc = 0; hc < HID_CELLS; hc++) begin
            for (int off = 0; off < FIELD; off++) begin
               for (int ci = 0; ci < 2; ci++) begin
                  r = blank_request(MODE_WRITE_WEIGHT);
                  r.weight_index = used_weight_addr(hi ? HID_COLS - 1 : 0, hc, off,
                                                    ci ? VIS_CELLS - 1 : 0);
                  r.weight_value = random_weight();
                  send_request(r);
               end
            end
         end
      end
   endtask

   task automatic test_directed();
      request_t r;
      r = blank_request(MODE_WRITE_WEIGHT);
      r.weight_value = 16'sh7FFF;
      send_request(r);
      r.weight_index = WDEPTH - 1;
      r.weight_value = 16'sh8000;
      send_request(r);
      // Writes beyond the store are dropped and reads there return zero.
      r.weight_index = WDEPTH;
      send_request(r);
      r.weight_index = 14'h3FFF;
      send_request(r);
      for (int i = 0; i < 4; i++) begin
         r = blank_request(MODE_READ_WEIGHT);
         r.weight_index = (i == 0) ? 0 : (i == 1) ? WDEPTH - 1 :
                          (i == 2) ? WDEPTH : 14'h3FFF;
         send_request(r);
      end
      r = blank_request(MODE_WRITE_VIS);
      r.layer = 1;
      r.vis_x = 15;
      r.vis_y = 15;
      r.vis_cell = 7;
      send_request(r);
      for (int c = 0; c < 4; c++) begin
         r = blank_request(c[0] ? MODE_LEARN : MODE_FORWARD);
         r.center_x = c < 2 ? 0 : 15;
         r.center_y = c < 2 ? 0 : 15;
         r.hid_index = c < 2 ? 0 : 15;
         r.target_cell = c[1] ? 7 : 0;
         send_request(r);
      end
      r = blank_request(MODE_FORWARD);
      r.center_x = 7;
      r.center_y = 8;
      send_request(r);
      for (int m = MODE_BAD_LOW; m <= 7; m++) send_request(blank_request(3'(m)));
   endtask

   // Empty field and one-column grid, then oversized grid values that saturate.
   task automatic test_grid_extremes();
      request_t r;
      drain();
      write_csr(CSR_RESERVED, 16'hFFFF);
      set_grid(0, 5, 65535);
      for (int m = 0; m < 2; m++) begin
         r = blank_request(m ? MODE_LEARN : MODE_FORWARD);
         r.center_x = 3;
         r.center_y = 3;
         send_request(r);
      end
      set_grid(1, 1, 65535);
      for (int m = 0; m < 4; m++) begin
         r = blank_request(m[0] ? MODE_LEARN : MODE_FORWARD);
         r.center_x = m[1];
         r.target_cell = 3;
         send_request(r);
      end
      set_grid(31, 31, 0);
      r = blank_request(MODE_LEARN);
      r.center_x = 15;
      r.center_y = 15;
      send_request(r);
   endtask

   task automatic test_random(int count, int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if (i % 160 == 159) begin
            case ($urandom_range(3))
               0: set_grid(16, 16, 6554);
               1: set_grid($urandom_range(1, 16), $urandom_range(1, 16),
                           $urandom_range(0, 65535));
               2: set_grid($urandom_range(0, 31), $urandom_range(0, 31), 65535);
               default: set_grid(16, 16, $urandom_range(30000, 65535));
            endcase
         end
         send_request(random_request());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_preload();
      test_directed();
      test_grid_extremes();
      set_grid(16, 16, 6554);
      test_random(360, 35);
      test_random(360, 68);
      test_random(360, 0);
      drain();
      if (pending_responses.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
